/* sv/bcf_pkg.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bcf_pkg - shared types and constants for the crossover filter
// Sizes, register indexes, history memory entry and result transaction.
// ---------------------------------------------------------------------------
package bcf_pkg;

   localparam int CHANNELS  = 8;
   localparam int CH_AW     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int CHAN_W    = 3;
   localparam int SAMPLE_W  = 32;
   localparam int COEF_W    = 32;
   localparam int HIST_W    = 48;
   localparam int FF_W      = 34;
   localparam int CSR_IDX_W = 3;
   localparam int OUT_DEPTH = 16;
   localparam int OUT_AW    = $clog2(OUT_DEPTH);

   localparam logic [CSR_IDX_W-1:0] CSR_LOW_GAIN_A0      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_FEEDBACK_B0  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LOW_FEEDBACK_B1  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_GAIN_A0     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_FEEDBACK_B0 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HIGH_FEEDBACK_B1 = 3'd5;

   // one history entry per channel: last two inputs and last two outputs of each band
   typedef struct packed {
      logic signed [SAMPLE_W-1:0] x0;
      logic signed [SAMPLE_W-1:0] x1;
      logic signed [HIST_W-1:0]   lo_y0;
      logic signed [HIST_W-1:0]   lo_y1;
      logic signed [HIST_W-1:0]   hi_y0;
      logic signed [HIST_W-1:0]   hi_y1;
   } hist_type;

   typedef struct packed {
      logic             en;
      logic [CH_AW-1:0] addr;
      hist_type         data;
   } hist_wr_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] low_out;
      logic signed [SAMPLE_W-1:0] high_out;
      logic                       low_clipped;
      logic                       high_clipped;
   } rsp_type;

endpackage
`default_nettype wire

/* sv/butterworth_crossover_filter_top.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// butterworth_crossover_filter_top - two-band biquad crossover, 8 channels
// Splits each sample into a lowpass and a negated highpass band, with the
// per-channel filter history held in an on-chip memory.
// ---------------------------------------------------------------------------
// Accepts one sample per clock as long as no channel repeats while its
// history is still being updated and the result queue has room; a sample
// of the same channel is taken only after the previous one of that channel
// has written its history back, since its history is read from the history
// memory at accept and written back only after the multiply-accumulate
// pipeline has produced the new outputs. Results pass to the rsp channel
// through a 16-entry result queue that absorbs result-side stalls;
// req_stall rises when it has no space reserved for another sample. History
// is zero after reset with no clearing pass. Coefficients must be written
// while the block is idle.
// ---------------------------------------------------------------------------
module butterworth_crossover_filter_top (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [bcf_pkg::CHAN_W-1:0]            req_channel,
   input  logic signed [bcf_pkg::SAMPLE_W-1:0]   req_sample_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic signed [bcf_pkg::SAMPLE_W-1:0]   rsp_low_out,
   output logic signed [bcf_pkg::SAMPLE_W-1:0]   rsp_high_out,
   output logic                                  rsp_low_clipped,
   output logic                                  rsp_high_clipped,
   input  logic                                  csr_write_en,
   input  logic [bcf_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [bcf_pkg::COEF_W-1:0]            csr_wdata
);
   import bcf_pkg::*;

   localparam int STAGES = 7;
   localparam int HAZ_STAGES = 5;

   // coefficient registers
   logic signed [COEF_W-1:0] low_a0_ff, low_b0_ff, low_b1_ff;
   logic signed [COEF_W-1:0] high_a0_ff, high_b0_ff, high_b1_ff;

   // pipeline control, index 0 is the stage right after accept
   logic [STAGES-1:0]   vld_ff;
   logic [CHAN_W-1:0]   ch_ff [HAZ_STAGES];
   logic                in_range;
   logic                hazard;
   logic                accept;
   logic                enter;
   logic                pop;
   logic [OUT_AW:0]     credit_ff, credit_in;

   // datapath carried alongside the lanes
   logic signed [SAMPLE_W-1:0] x_s1_ff;
   hist_type                   rd_hist;
   logic signed [FF_W-1:0]     ff_lo_in, ff_lo_ff, ff_hi_in, ff_hi_ff;
   logic signed [HIST_W-1:0]   lo_y1_ff, hi_y1_ff;
   logic signed [SAMPLE_W-1:0] x_ff     [4];
   logic signed [SAMPLE_W-1:0] x0_ff    [4];
   logic signed [HIST_W-1:0]   lo_y0_ff [4];
   logic signed [HIST_W-1:0]   hi_y0_ff [4];

   logic signed [HIST_W-1:0]   lo_y_next, hi_y_next;
   logic signed [SAMPLE_W-1:0] lo_sample, hi_sample;
   logic                       lo_clip, hi_clip;
   hist_wr_type                hist_wr;
   rsp_type                    push_data;
   rsp_type                    fifo_data;

   // ---------------- configuration ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         low_a0_ff  <= '0;
         low_b0_ff  <= '0;
         low_b1_ff  <= '0;
         high_a0_ff <= '0;
         high_b0_ff <= '0;
         high_b1_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_LOW_GAIN_A0:      low_a0_ff  <= $signed(csr_wdata);
            CSR_LOW_FEEDBACK_B0:  low_b0_ff  <= $signed(csr_wdata);
            CSR_LOW_FEEDBACK_B1:  low_b1_ff  <= $signed(csr_wdata);
            CSR_HIGH_GAIN_A0:     high_a0_ff <= $signed(csr_wdata);
            CSR_HIGH_FEEDBACK_B0: high_b0_ff <= $signed(csr_wdata);
            CSR_HIGH_FEEDBACK_B1: high_b1_ff <= $signed(csr_wdata);
            default: ;
         endcase
      end
   end

   // ---------------- accept and interlock ----------------
   always_comb begin
      hazard = 1'b0;
      for (int i = 0; i < HAZ_STAGES; i++) begin
         if (vld_ff[i] && ch_ff[i] == req_channel) begin
            hazard = 1'b1;
         end
      end
   end

   assign in_range  = (int'(req_channel) < CHANNELS);
   // hold while the channel's history is still being updated or the queue has no room
   assign req_stall = hazard || (credit_ff == (OUT_AW + 1)'(OUT_DEPTH));
   assign accept    = req_valid && !req_stall;
   // drop samples of channels that do not exist
   assign enter     = accept && in_range;
   assign pop       = rsp_valid && !rsp_stall;

   always_comb begin
      credit_in = credit_ff;
      if (enter && !pop) begin
         credit_in = credit_ff + 1'b1;
      end else if (!enter && pop) begin
         credit_in = credit_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff    <= '0;
         credit_ff <= '0;
      end else begin
         vld_ff    <= {vld_ff[STAGES-2:0], enter};
         credit_ff <= credit_in;
      end
   end

   always_ff @(posedge clock) begin
      ch_ff[0] <= req_channel;
      for (int i = 1; i < HAZ_STAGES; i++) begin
         ch_ff[i] <= ch_ff[i-1];
      end
   end

   // ---------------- history memory ----------------
   bcf_hist_mem u_hist (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (CH_AW'(req_channel)),
      .rd_data (rd_hist),
      .wr      (hist_wr)
   );

   // ---------------- feed-forward sums ----------------
   always_comb begin
      ff_lo_in = FF_W'(x_s1_ff) + (FF_W'($signed(rd_hist.x0)) <<< 1)
               + FF_W'($signed(rd_hist.x1));
      ff_hi_in = FF_W'(x_s1_ff) - (FF_W'($signed(rd_hist.x0)) <<< 1)
               + FF_W'($signed(rd_hist.x1));
   end

   always_ff @(posedge clock) begin
      x_s1_ff     <= req_sample_in;
      ff_lo_ff    <= ff_lo_in;
      ff_hi_ff    <= ff_hi_in;
      lo_y1_ff    <= rd_hist.lo_y1;
      hi_y1_ff    <= rd_hist.hi_y1;
      x_ff[0]     <= x_s1_ff;
      x0_ff[0]    <= rd_hist.x0;
      lo_y0_ff[0] <= rd_hist.lo_y0;
      hi_y0_ff[0] <= rd_hist.hi_y0;
      for (int i = 1; i < 4; i++) begin
         x_ff[i]     <= x_ff[i-1];
         x0_ff[i]    <= x0_ff[i-1];
         lo_y0_ff[i] <= lo_y0_ff[i-1];
         hi_y0_ff[i] <= hi_y0_ff[i-1];
      end
   end

   // ---------------- filter lanes ----------------
   bcf_biquad_lane u_low (
      .clock   (clock),
      .a0      (low_a0_ff),
      .b0      (low_b0_ff),
      .b1      (low_b1_ff),
      .ff      (ff_lo_ff),
      .y0      (lo_y0_ff[0]),
      .y1      (lo_y1_ff),
      .y_next  (lo_y_next),
      .sample  (lo_sample),
      .clipped (lo_clip)
   );

   bcf_biquad_lane u_high (
      .clock   (clock),
      .a0      (high_a0_ff),
      .b0      (high_b0_ff),
      .b1      (high_b1_ff),
      .ff      (ff_hi_ff),
      .y0      (hi_y0_ff[0]),
      .y1      (hi_y1_ff),
      .y_next  (hi_y_next),
      .sample  (hi_sample),
      .clipped (hi_clip)
   );

   // ---------------- write back shifted history ----------------
   always_comb begin
      hist_wr.en         = vld_ff[4];
      hist_wr.addr       = CH_AW'(ch_ff[4]);
      hist_wr.data.x0    = x_ff[3];
      hist_wr.data.x1    = x0_ff[3];
      hist_wr.data.lo_y0 = lo_y_next;
      hist_wr.data.lo_y1 = lo_y0_ff[3];
      hist_wr.data.hi_y0 = hi_y_next;
      hist_wr.data.hi_y1 = hi_y0_ff[3];
   end

   // ---------------- results ----------------
   always_comb begin
      push_data.low_out      = lo_sample;
      push_data.low_clipped  = lo_clip;
      push_data.high_clipped = hi_clip;
      // negating the most negative value saturates to the maximum
      if (hi_sample == $signed({1'b1, 31'd0})) begin
         push_data.high_out = $signed({1'b0, {31{1'b1}}});
      end else begin
         push_data.high_out = -hi_sample;
      end
   end

   bcf_out_fifo u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (vld_ff[STAGES-1]),
      .push_data (push_data),
      .pop       (pop),
      .valid     (rsp_valid),
      .data      (fifo_data)
   );

   assign rsp_low_out      = fifo_data.low_out;
   assign rsp_high_out     = fifo_data.high_out;
   assign rsp_low_clipped  = fifo_data.low_clipped;
   assign rsp_high_clipped = fifo_data.high_clipped;

`ifndef SYNTH
   a_credit_bound: assert property (@(posedge clock) disable iff (reset)
      credit_ff <= (OUT_AW + 1)'(OUT_DEPTH))
      else $error("credit count beyond queue depth");

   a_credit_covers_pipe: assert property (@(posedge clock) disable iff (reset)
      $countones(vld_ff) <= int'(credit_ff))
      else $error("transactions in flight without reserved queue space");

   a_no_same_channel: assert property (@(posedge clock) disable iff (reset)
      (vld_ff[0] && vld_ff[1]) |-> (ch_ff[0] != ch_ff[1]))
      else $error("same channel in adjacent history stages");

   a_enter_tracked: assert property (@(posedge clock) disable iff (reset)
      enter |=> (vld_ff[0] && ch_ff[0] == $past(req_channel)))
      else $error("accepted transaction not tracked in pipeline");
`endif

endmodule
`default_nettype wire

/* sv/bcf_hist_mem.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bcf_hist_mem - per-channel filter history memory
// One entry per channel, one write and one registered read per cycle.
// Entries never written since reset read as zero through per-entry valid bits.
// ---------------------------------------------------------------------------
module bcf_hist_mem (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [bcf_pkg::CH_AW-1:0] rd_addr,
   output bcf_pkg::hist_type         rd_data,
   input  bcf_pkg::hist_wr_type      wr
);
   import bcf_pkg::*;

   hist_type            mem [CHANNELS];
   hist_type            rd_data_ff;
   logic                rd_valid_ff;
   logic [CHANNELS-1:0] valid_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= valid_ff[rd_addr];
         if (wr.en) begin
            valid_ff[wr.addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_data_ff : '0;

endmodule
`default_nettype wire

/* sv/bcf_biquad_lane.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bcf_biquad_lane - multiply-accumulate datapath of one biquad band
// Split partial products, term sums, accumulate, round and saturate to
// Q36.12, then round and clip to a 32-bit sample. Free running, no stall.
// ---------------------------------------------------------------------------
module bcf_biquad_lane (
   input  logic                                clock,
   input  logic signed [bcf_pkg::COEF_W-1:0]   a0,
   input  logic signed [bcf_pkg::COEF_W-1:0]   b0,
   input  logic signed [bcf_pkg::COEF_W-1:0]   b1,
   input  logic signed [bcf_pkg::FF_W-1:0]     ff,
   input  logic signed [bcf_pkg::HIST_W-1:0]   y0,
   input  logic signed [bcf_pkg::HIST_W-1:0]   y1,
   output logic signed [bcf_pkg::HIST_W-1:0]   y_next,
   output logic signed [bcf_pkg::SAMPLE_W-1:0] sample,
   output logic                                clipped
);
   import bcf_pkg::*;

   // partial products
   logic signed [49:0] p_ff_lo_in, p_ff_lo_ff;
   logic signed [48:0] p_ff_hi_in, p_ff_hi_ff;
   logic signed [56:0] p_b0_lo_in, p_b0_lo_ff, p_b1_lo_in, p_b1_lo_ff;
   logic signed [55:0] p_b0_hi_in, p_b0_hi_ff, p_b1_hi_in, p_b1_hi_ff;
   // full terms
   logic [65:0] t_ff_in, t_ff_ff;
   logic [79:0] t_b0_in, t_b0_ff, t_b1_in, t_b1_ff;
   // accumulator at scale 2^-41
   logic [81:0] acc_in, acc_ff;
   logic [81:0] acc_rnd;
   logic [52:0] acc_q;
   logic signed [HIST_W-1:0]   y_ff;
   logic [48:0]                out_rnd;
   logic [36:0]                out_q;
   logic signed [SAMPLE_W-1:0] sample_in, sample_ff;
   logic                       clipped_in, clipped_ff;

   always_comb begin
      p_ff_lo_in = a0 * $signed({1'b0, ff[16:0]});
      p_ff_hi_in = a0 * $signed(ff[33:17]);
      p_b0_lo_in = b0 * $signed({1'b0, y0[23:0]});
      p_b0_hi_in = b0 * $signed(y0[47:24]);
      p_b1_lo_in = b1 * $signed({1'b0, y1[23:0]});
      p_b1_hi_in = b1 * $signed(y1[47:24]);
   end

   always_comb begin
      t_ff_in = {p_ff_hi_ff, 17'd0} + {{16{p_ff_lo_ff[49]}}, p_ff_lo_ff};
      t_b0_in = {p_b0_hi_ff, 24'd0} + {{23{p_b0_lo_ff[56]}}, p_b0_lo_ff};
      t_b1_in = {p_b1_hi_ff, 24'd0} + {{23{p_b1_lo_ff[56]}}, p_b1_lo_ff};
   end

   // feed-forward term sits 12 bits higher since history is Q36.12
   assign acc_in = {{4{t_ff_ff[65]}}, t_ff_ff, 12'd0}
                 - {{2{t_b0_ff[79]}}, t_b0_ff}
                 - {{2{t_b1_ff[79]}}, t_b1_ff};

   // round half up to Q36.12 and saturate to 48 bits
   always_comb begin
      acc_rnd = acc_ff + {53'd0, 1'b1, 28'd0};
      acc_q   = acc_rnd[81:29];
      if (acc_q[52:47] == {6{acc_q[47]}}) begin
         y_next = $signed(acc_q[47:0]);
      end else if (acc_q[52]) begin
         y_next = $signed({1'b1, 47'd0});
      end else begin
         y_next = $signed({1'b0, {47{1'b1}}});
      end
   end

   // round half up to an integer and clip to 32 bits
   always_comb begin
      out_rnd = {y_ff[47], y_ff} + 49'd2048;
      out_q   = out_rnd[48:12];
      if (out_q[36:31] == {6{out_q[31]}}) begin
         sample_in  = $signed(out_q[31:0]);
         clipped_in = 1'b0;
      end else begin
         sample_in  = out_q[36] ? $signed({1'b1, 31'd0}) : $signed({1'b0, {31{1'b1}}});
         clipped_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      p_ff_lo_ff <= p_ff_lo_in;
      p_ff_hi_ff <= p_ff_hi_in;
      p_b0_lo_ff <= p_b0_lo_in;
      p_b0_hi_ff <= p_b0_hi_in;
      p_b1_lo_ff <= p_b1_lo_in;
      p_b1_hi_ff <= p_b1_hi_in;
      t_ff_ff    <= t_ff_in;
      t_b0_ff    <= t_b0_in;
      t_b1_ff    <= t_b1_in;
      acc_ff     <= acc_in;
      y_ff       <= y_next;
      sample_ff  <= sample_in;
      clipped_ff <= clipped_in;
   end

   assign sample  = sample_ff;
   assign clipped = clipped_ff;

endmodule
`default_nettype wire

/* sv/bcf_out_fifo.sv */
`default_nettype none
// ---------------------------------------------------------------------------
// bcf_out_fifo - result queue
// Holds finished results so the pipeline keeps running while the result
// channel stalls. Space is reserved upstream before an item enters.
// ---------------------------------------------------------------------------
module bcf_out_fifo (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  bcf_pkg::rsp_type push_data,
   input  logic             pop,
   output logic             valid,
   output bcf_pkg::rsp_type data
);
   import bcf_pkg::*;

   rsp_type           entry_ff [OUT_DEPTH];
   logic [OUT_AW:0]   wr_ptr_ff, wr_ptr_in;
   logic [OUT_AW:0]   rd_ptr_ff, rd_ptr_in;
   logic              full;

   assign valid = (wr_ptr_ff != rd_ptr_ff);
   assign full  = (wr_ptr_ff == {~rd_ptr_ff[OUT_AW], rd_ptr_ff[OUT_AW-1:0]});
   assign data  = entry_ff[rd_ptr_ff[OUT_AW-1:0]];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = (pop && valid) ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff[OUT_AW-1:0]] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

`ifndef SYNTH
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("result queue overflow");

   a_drain_by_pop: assert property (@(posedge clock) disable iff (reset)
      $fell(valid) |-> $past(pop))
      else $error("result queue emptied without a pop");
`endif

endmodule
`default_nettype wire
